[design/lcdfmt_pkg.sv]
// ----------------------------------------------------------------------------
// Segment LCD field formatter package
// Command codes, controller states, segment codes and the fixed segment bit
// addresses of every display field.
// ----------------------------------------------------------------------------
package lcdfmt_pkg;

    localparam int VALUE_W     = 16;
    localparam int BCD_DIGITS  = 4;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int REM_W       = 6;
    localparam int SEG_W       = 7;
    localparam int ADDR_W      = 7;
    localparam int FIELD_BYTES = 12;
    localparam int FIELD_BITS  = 8 * FIELD_BYTES;
    localparam int BYTE_IDX_W  = 5;

    localparam logic [REM_W:0] SECONDS_PER_MINUTE = 7'd60;

    typedef enum logic [3:0] {
        CMD_CLEAR     = 4'd0,
        CMD_ALL_ON    = 4'd1,
        CMD_CALORIE   = 4'd2,
        CMD_TIME      = 4'd3,
        CMD_DISTANCE  = 4'd4,
        CMD_WATT      = 4'd5,
        CMD_SPEED     = 4'd6,
        CMD_COUNT     = 4'd7,
        CMD_LEVEL     = 4'd8,
        CMD_HEART_VAL = 4'd9,
        CMD_BATTERY   = 4'd10,
        CMD_NFC       = 4'd11,
        CMD_BLE       = 4'd12,
        CMD_HEART     = 4'd13,
        CMD_BAR       = 4'd14,
        CMD_FLUSH     = 4'd15
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_APPLY,
        ST_FLUSH
    } state_t;

    typedef logic [ADDR_W-1:0] addr_t;

    localparam addr_t POS_BIG [4][7] = '{
        '{7'd54, 7'd53, 7'd52, 7'd59, 7'd49, 7'd55, 7'd48},
        '{7'd63, 7'd62, 7'd61, 7'd60, 7'd58, 7'd56, 7'd57},
        '{7'd68, 7'd75, 7'd74, 7'd73, 7'd71, 7'd69, 7'd70},
        '{7'd77, 7'd76, 7'd83, 7'd82, 7'd72, 7'd78, 7'd79}
    };
    localparam addr_t POS_MID [3][7] = '{
        '{7'd37, 7'd36, 7'd43, 7'd42, 7'd41, 7'd47, 7'd40},
        '{7'd28, 7'd35, 7'd34, 7'd33, 7'd32, 7'd38, 7'd39},
        '{7'd20, 7'd27, 7'd26, 7'd25, 7'd24, 7'd30, 7'd31}
    };
    localparam addr_t POS_LOW [3][7] = '{
        '{7'd13, 7'd12, 7'd19, 7'd18, 7'd17, 7'd23, 7'd16},
        '{7'd4,  7'd11, 7'd10, 7'd9,  7'd8,  7'd14, 7'd15},
        '{7'd3,  7'd2,  7'd1,  7'd0,  7'd7,  7'd5,  7'd6}
    };
    localparam addr_t BAT_ADDR [6] = '{7'd84, 7'd86, 7'd85, 7'd87, 7'd80, 7'd81};

    localparam addr_t ADDR_COLON_UP   = 7'd65;
    localparam addr_t ADDR_COLON_DOWN = 7'd66;
    localparam addr_t ADDR_BIG_POINT  = 7'd67;
    localparam addr_t ADDR_MID_POINT  = 7'd29;
    localparam addr_t ADDR_WATT_MARK  = 7'd45;
    localparam addr_t ADDR_SPEED_MARK = 7'd46;
    localparam addr_t ADDR_COUNT_MARK = 7'd21;
    localparam addr_t ADDR_LEVEL_MARK = 7'd22;
    localparam addr_t ADDR_NFC        = 7'd91;
    localparam addr_t ADDR_BLE        = 7'd90;
    localparam addr_t ADDR_HEART      = 7'd89;
    localparam addr_t ADDR_BAR        = 7'd64;

    function automatic logic [SEG_W-1:0] seg7(input logic [3:0] digit, input logic show);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return show ? pat : '0;
    endfunction

    function automatic logic [3:0] sec_tens(input logic [REM_W-1:0] sec);
        logic [3:0] tens;
        if (sec >= 6'd50)
            tens = 4'd5;
        else if (sec >= 6'd40)
            tens = 4'd4;
        else if (sec >= 6'd30)
            tens = 4'd3;
        else if (sec >= 6'd20)
            tens = 4'd2;
        else if (sec >= 6'd10)
            tens = 4'd1;
        else
            tens = 4'd0;
        return tens;
    endfunction

    function automatic logic [3:0] sec_units(input logic [REM_W-1:0] sec);
        logic [REM_W-1:0] tens_val;
        tens_val = REM_W'(sec_tens(sec)) * 6'd10;
        return 4'(sec - tens_val);
    endfunction

    function automatic logic [FIELD_BITS-1:0] put_digit(
        input logic [FIELD_BITS-1:0] bits,
        input addr_t                 addrs [7],
        input logic [SEG_W-1:0]      pat
    );
        logic [FIELD_BITS-1:0] res;
        res = bits;
        for (int s = 0; s < SEG_W; s++)
        begin
            res[addrs[s]] = pat[s];
        end
        return res;
    endfunction

endpackage

[design/lcdfmt_bcd_serial.sv]
// ----------------------------------------------------------------------------
// Serial binary to decimal converter
// Shifts the value in one bit per cycle, most significant first, through a
// shift-and-add-three digit register. In seconds mode each bit first passes
// a serial divider by sixty, so the digits hold minutes and the remainder
// holds the seconds.
// ----------------------------------------------------------------------------
module lcdfmt_bcd_serial
    import lcdfmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               div60,
    input  logic [VALUE_W-1:0] bin,
    output logic               done,
    output logic [BCD_W-1:0]   bcd,
    output logic [REM_W-1:0]   rem
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               run_reg,   run_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic               mode_reg,  mode_next;
    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [REM_W-1:0]   rem_reg,   rem_next;
    logic [BCD_W-1:0]   bcd_reg,   bcd_next;

    logic [REM_W:0]     rem_trial;
    logic               qbit;
    logic               bit_in;
    logic [BCD_W-1:0]   bcd_adj;

    assign rem_trial = {rem_reg, shift_reg[VALUE_W-1]};
    assign qbit      = rem_trial >= SECONDS_PER_MINUTE;
    assign bit_in    = mode_reg ? qbit : shift_reg[VALUE_W-1];
    assign done      = run_reg && (cnt_reg == CNT_W'(VALUE_W - 1));

    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        run_next   = run_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        bcd_next   = bcd_reg;
        if (load)
        begin
            run_next   = 1'b1;
            cnt_next   = '0;
            mode_next  = div60;
            shift_next = bin;
            rem_next   = '0;
            bcd_next   = '0;
        end
        else if (run_reg)
        begin
            cnt_next   = cnt_reg + 1'b1;
            run_next   = !done;
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            rem_next   = qbit ? REM_W'(rem_trial - SECONDS_PER_MINUTE) : rem_trial[REM_W-1:0];
            bcd_next   = {bcd_adj[BCD_W-2:0], bit_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        bcd_reg   <= bcd_next;
    end

    assign bcd = bcd_reg;
    assign rem = rem_reg;

endmodule

[design/segment_lcd_field_formatter_core.sv]
// ----------------------------------------------------------------------------
// Segment LCD field formatter core
// Keeps the LCD segment map, writes display fields into it and streams the
// map out byte by byte on a flush.
// ----------------------------------------------------------------------------
// Clear, all-on, battery and icon items are written into the map when taken;
// busy stays low. Numeric field items hold busy while the serial decimal
// converter runs (ST_CONVERT) and while the segments are written (ST_APPLY).
// A flush holds busy until the map is read out; the first byte is strobed once
// state_reg and strobe_reg are passed, then one byte per cycle without gaps.
// Reset clears the segment map (display blank) and returns the core to idle.
module segment_lcd_field_formatter_core
    import lcdfmt_pkg::*;
#(
    parameter int MAP_BYTES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [3:0]            cmd,
    input  logic [VALUE_W-1:0]    value,
    input  logic                  flag,
    output logic                  strobe,
    output logic [BYTE_IDX_W-1:0] byte_index,
    output logic [7:0]            byte_data,
    output logic                  last
);

    localparam int IDX_W = $clog2(MAP_BYTES);

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg,   cmd_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic                  flag_reg,  flag_next;
    logic [IDX_W-1:0]      idx_reg,   idx_next;
    logic [7:0]            map_reg [MAP_BYTES];
    logic [7:0]            map_next [MAP_BYTES];
    logic                  strobe_reg, strobe_next;
    logic [BYTE_IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]            byte_data_reg,  byte_data_next;
    logic                  last_reg,       last_next;

    cmd_t                  in_cmd;
    logic                  accept;
    logic                  digit_cmd;
    logic                  conv_load;
    logic                  conv_done;
    logic                  flush_step;
    logic                  idx_at_end;
    logic                  apply;
    logic                  direct_upd;
    logic                  fill;
    logic [BCD_W-1:0]      bcd;
    logic [REM_W-1:0]      rem;

    cmd_t                  op_cmd;
    logic [VALUE_W-1:0]    op_value;
    logic                  op_flag;
    logic [FIELD_BITS-1:0] field_bits;
    logic [FIELD_BITS-1:0] field_new;
    logic [3:0]            dig [4];
    logic                  ge100;
    logic                  ge10;

    assign in_cmd     = cmd_t'(cmd);
    assign accept     = start && !busy;
    assign digit_cmd  = in_cmd inside {[CMD_CALORIE:CMD_HEART_VAL]};
    assign idx_at_end = idx_reg == IDX_W'(MAP_BYTES - 1);

    lcdfmt_bcd_serial u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (conv_load),
        .div60 (in_cmd == CMD_TIME),
        .bin   (value),
        .done  (conv_done),
        .bcd   (bcd),
        .rem   (rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_cmd == CMD_FLUSH)
                    state_next = ST_FLUSH;
                else if (accept && digit_cmd)
                    state_next = ST_CONVERT;
            end
            ST_CONVERT:
            begin
                if (conv_done)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
                state_next = ST_IDLE;
            ST_FLUSH:
            begin
                if (idx_at_end)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = state_reg != ST_IDLE;
        conv_load  = accept && digit_cmd;
        flush_step = state_reg == ST_FLUSH;
        apply      = state_reg == ST_APPLY;
        direct_upd = accept && (in_cmd inside {[CMD_BATTERY:CMD_BAR]});
        fill       = accept && (in_cmd == CMD_CLEAR || in_cmd == CMD_ALL_ON);
    end

    assign op_cmd   = apply ? cmd_reg   : in_cmd;
    assign op_value = apply ? value_reg : value;
    assign op_flag  = apply ? flag_reg  : flag;
    assign ge100    = op_value >= 16'd100;
    assign ge10     = op_value >= 16'd10;

    always_comb
    begin
        if (cmd_reg == CMD_TIME)
        begin
            dig[0] = bcd[7:4];
            dig[1] = bcd[3:0];
            dig[2] = sec_tens(rem);
            dig[3] = sec_units(rem);
        end
        else
        begin
            dig[0] = bcd[15:12];
            dig[1] = bcd[11:8];
            dig[2] = bcd[7:4];
            dig[3] = bcd[3:0];
        end
    end

    always_comb
    begin
        for (int a = 0; a < FIELD_BITS; a++)
        begin
            field_bits[a] = map_reg[a >> 3][3'(7 - (a & 7))];
        end
        field_new = field_bits;
        case (op_cmd)
            CMD_CALORIE, CMD_DISTANCE:
            begin
                field_new = put_digit(field_new, POS_BIG[0], seg7(dig[0], dig[0] != 4'd0));
                field_new = put_digit(field_new, POS_BIG[1],
                    seg7(dig[1], op_cmd == CMD_DISTANCE || dig[1] != 4'd0));
                field_new = put_digit(field_new, POS_BIG[2],
                    seg7(dig[2], op_cmd == CMD_DISTANCE || dig[2] != 4'd0));
                field_new = put_digit(field_new, POS_BIG[3], seg7(dig[3], 1'b1));
                field_new[ADDR_COLON_UP]   = 1'b0;
                field_new[ADDR_COLON_DOWN] = 1'b0;
                field_new[ADDR_BIG_POINT]  = op_cmd == CMD_DISTANCE;
            end
            CMD_TIME:
            begin
                field_new = put_digit(field_new, POS_BIG[0], seg7(dig[0], 1'b1));
                field_new = put_digit(field_new, POS_BIG[1], seg7(dig[1], 1'b1));
                field_new = put_digit(field_new, POS_BIG[2], seg7(dig[2], 1'b1));
                field_new = put_digit(field_new, POS_BIG[3], seg7(dig[3], 1'b1));
                field_new[ADDR_COLON_UP]   = op_flag;
                field_new[ADDR_COLON_DOWN] = op_flag;
                field_new[ADDR_BIG_POINT]  = 1'b0;
            end
            CMD_WATT, CMD_SPEED:
            begin
                field_new = put_digit(field_new, POS_MID[0], seg7(dig[1], dig[1] != 4'd0));
                field_new = put_digit(field_new, POS_MID[1], seg7(dig[2], 1'b1));
                field_new = put_digit(field_new, POS_MID[2], seg7(dig[3], 1'b1));
                field_new[ADDR_MID_POINT]  = op_cmd == CMD_SPEED;
                field_new[ADDR_WATT_MARK]  = op_cmd != CMD_SPEED;
                field_new[ADDR_SPEED_MARK] = op_cmd == CMD_SPEED;
            end
            CMD_COUNT, CMD_HEART_VAL:
            begin
                field_new = put_digit(field_new, POS_LOW[0], seg7(dig[1], ge100));
                field_new = put_digit(field_new, POS_LOW[1], seg7(dig[2], ge10));
                field_new = put_digit(field_new, POS_LOW[2], seg7(dig[3], 1'b1));
                field_new[ADDR_COUNT_MARK] = op_cmd == CMD_COUNT;
                field_new[ADDR_LEVEL_MARK] = 1'b0;
            end
            CMD_LEVEL:
            begin
                field_new = put_digit(field_new, POS_LOW[0], seg7(dig[1], dig[1] != 4'd0));
                field_new = put_digit(field_new, POS_LOW[1], seg7(dig[2], dig[2] != 4'd0));
                field_new = put_digit(field_new, POS_LOW[2], seg7(dig[3], 1'b1));
                field_new[ADDR_COUNT_MARK] = 1'b0;
                field_new[ADDR_LEVEL_MARK] = 1'b1;
            end
            CMD_BATTERY:
            begin
                for (int k = 0; k < 6; k++)
                begin
                    field_new[BAT_ADDR[k]] = op_value > VALUE_W'(k);
                end
            end
            CMD_NFC:   field_new[ADDR_NFC]   = op_flag;
            CMD_BLE:   field_new[ADDR_BLE]   = op_flag;
            CMD_HEART: field_new[ADDR_HEART] = op_flag;
            CMD_BAR:   field_new[ADDR_BAR]   = op_flag;
            default:   field_new = field_bits;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAP_BYTES; i++)
        begin
            map_next[i] = map_reg[i];
            if (fill)
                map_next[i] = (in_cmd == CMD_ALL_ON) ? 8'hFF : 8'h00;
            else if ((apply || direct_upd) && i < FIELD_BYTES)
            begin
                for (int b = 0; b < 8; b++)
                begin
                    map_next[i][7 - b] = field_new[8 * i + b];
                end
            end
        end
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        flag_next       = flag_reg;
        idx_next        = idx_reg;
        if (accept)
        begin
            cmd_next   = in_cmd;
            value_next = value;
            flag_next  = flag;
            idx_next   = '0;
        end
        else if (flush_step)
            idx_next = idx_reg + 1'b1;
        strobe_next     = flush_step;
        byte_index_next = BYTE_IDX_W'(idx_reg);
        byte_data_next  = map_reg[idx_reg];
        last_next       = idx_at_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < MAP_BYTES; i++)
            begin
                map_reg[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
            for (int i = 0; i < MAP_BYTES; i++)
            begin
                map_reg[i] <= map_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        flag_reg       <= flag_next;
        byte_index_reg <= byte_index_next;
        byte_data_reg  <= byte_data_next;
        last_reg       <= last_next;
    end

    assign strobe     = strobe_reg;
    assign byte_index = byte_index_reg;
    assign byte_data  = byte_data_reg;
    assign last       = last_reg && strobe_reg;

endmodule

[design/lcdfmt_checker.sv]
// ----------------------------------------------------------------------------
// Segment LCD field formatter port checker
// Watches the ports of the core and checks the ordering of the flush stream.
// ----------------------------------------------------------------------------
module lcdfmt_checker
    import lcdfmt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [3:0]            cmd,
    input logic                  strobe,
    input logic [BYTE_IDX_W-1:0] byte_index,
    input logic                  last
);

    logic flush_taken;

    assign flush_taken = start && !busy && (cmd == CMD_FLUSH);

    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        flush_taken |=> busy)
        else $error("flush item taken but core not busy");

    a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("byte strobed outside a flush run");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last raised without a byte");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && (byte_index == 5'($past(byte_index) + 5'd1)))
        else $error("flush stream gap or index out of order");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("byte strobed after the last byte of a flush");

endmodule

bind segment_lcd_field_formatter_core lcdfmt_checker u_lcdfmt_checker (.*);
